// ----- sv/hpt_pkg.sv -----
package hpt_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_RSVD     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] space_id;
    logic [31:0] page_addr;
    logic [31:0] frame_addr;
    logic        nocache_flag;
    logic        dirty_flag;
    logic        valid_flag;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] entry_low;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ISSUE,
    ST_LK_CHK,
    ST_IN_CHK,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_IN_LINK,
    ST_DH_CHK,
    ST_DH_RD,
    ST_DH_MOVE,
    ST_DH_CLR,
    ST_DW_STEP,
    ST_DW_CHK,
    ST_DW_CLR,
    ST_RESP
  } state_t;

  localparam int BIT_NOCACHE = 11;
  localparam int BIT_DIRTY   = 10;
  localparam int BIT_VALID   = 9;

  function automatic logic [31:0] pack_word(input in_t req);
    logic [31:0] w;
    w = req.frame_addr;
    if (req.nocache_flag) w[BIT_NOCACHE] = 1'b1;
    if (req.dirty_flag)   w[BIT_DIRTY]   = 1'b1;
    if (req.valid_flag)   w[BIT_VALID]   = 1'b1;
    return w;
  endfunction

endpackage

// ----- sv/hashed_page_table.sv -----
// Channel   Direction  Payload  Handshake
// in_       input      in_t     in_valid / in_stall
// out_      output     out_t    out_valid / out_stall
//
// After reset the table is swept clear, one slot per cycle; in_stall stays high
// throughout. A request then has its home slot formed by hpt_home_calc, and on a
// lookup or insert walk every slot read passes through an issue state and then a
// check state, as each read of the table memory is followed by checking; a delete
// takes every slot beyond the head through a step, an issue and a check state. An
// insert that must hunt for a free slot takes each scanned slot through a scan read
// and a scan check state. A finished result waits in the output register, and the
// next request is taken whilst it is held under out_stall.
module hashed_page_table
  import hpt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Index width and link width; a link of TABLE_ENTRIES or above is null.
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = 96 + LW;
  localparam logic [LW-1:0] NULL_LINK = LW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(TABLE_ENTRIES - 1);
  localparam logic [EW-1:0] CLEAR_ENT = {96'd0, NULL_LINK};

  state_t        state_r, state_nxt;
  in_t           req_r, req_nxt;
  logic [IW-1:0] home_r, home_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [LW-1:0] steps_r, steps_nxt;
  logic [EW-1:0] ent_r, ent_nxt;
  logic [31:0]   w_r, w_nxt;
  out_t          res_r, res_nxt;
  out_t          out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, rd_q;

  logic          hash_start, hash_done;
  logic [IW-1:0] hash_home;

  logic          in_xfer;
  logic          rd_match, rd_next, rd_free, ent_next;
  logic [31:0]   rd_word, new_word;
  logic [LW-1:0] rd_link;
  logic [EW-1:0] new_ent;

  hpt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_q)
  );

  hpt_home_calc #(
    .ENTRIES (TABLE_ENTRIES),
    .IW      (IW)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_data.space_id ^ in_data.page_addr),
    .done  (hash_done),
    .home  (hash_home)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Fields of the entry that the memory returned this cycle.
  assign rd_word  = rd_q[LW +: 32];
  assign rd_link  = rd_q[LW-1:0];
  assign rd_match = (rd_q[EW-1 -: 32] == req_r.space_id) &&
                    (rd_q[EW-33 -: 32] == req_r.page_addr);
  assign rd_next  = (rd_link < NULL_LINK);
  assign rd_free  = (rd_q[EW-1:LW] == 96'd0);
  assign ent_next = (ent_r[LW-1:0] < NULL_LINK);
  assign new_word = pack_word(req_r);
  assign new_ent  = {req_r.space_id, req_r.page_addr, new_word, NULL_LINK};

  // Every operation runs strictly in order on the one memory: writes only happen once
  // a request has made its last read of the table, so no read ever overlaps a pending write.
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    home_nxt   = home_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    scan_nxt   = scan_r;
    clr_nxt    = clr_r;
    steps_nxt  = steps_r;
    ent_nxt    = ent_r;
    w_nxt      = w_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_waddr  = cur_r;
    mem_wdata  = CLEAR_ENT;
    mem_raddr  = cur_r;
    hash_start = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + IW'(1);
        if (clr_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          req_nxt = in_data;
          if (in_data.kind == KIND_UNUSED) begin
            res_nxt   = '{status: STATUS_NO_MATCH, slot: '0, entry_low: '0};
            state_nxt = ST_RESP;
          end else begin
            hash_start = 1'b1;
            state_nxt  = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          home_nxt  = hash_home;
          cur_nxt   = hash_home;
          steps_nxt = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        priority if (req_r.kind == KIND_LOOKUP) begin
          state_nxt = ST_LK_CHK;
        end else if (req_r.kind == KIND_INSERT) begin
          state_nxt = ST_IN_CHK;
        end else if (steps_r == '0) begin
          state_nxt = ST_DH_CHK;
        end else begin
          state_nxt = ST_DW_CHK;
        end
      end
      ST_LK_CHK: begin
        if (rd_match && rd_word[BIT_VALID]) begin
          res_nxt   = '{status: STATUS_DONE, slot: 10'(cur_r), entry_low: rd_word};
          state_nxt = ST_RESP;
        end else if (!rd_next || steps_r == LW'(TABLE_ENTRIES - 1)) begin
          res_nxt   = '{status: STATUS_NO_MATCH, slot: '0, entry_low: '0};
          state_nxt = ST_RESP;
        end else begin
          cur_nxt   = rd_link[IW-1:0];
          steps_nxt = steps_r + LW'(1);
          state_nxt = ST_ISSUE;
        end
      end
      ST_IN_CHK: begin
        if (rd_next) begin
          if (steps_r == LW'(TABLE_ENTRIES - 1)) begin
            res_nxt   = '{status: STATUS_FULL, slot: '0, entry_low: '0};
            state_nxt = ST_RESP;
          end else begin
            cur_nxt   = rd_link[IW-1:0];
            steps_nxt = steps_r + LW'(1);
            state_nxt = ST_ISSUE;
          end
        end else if (rd_free) begin
          mem_we    = 1'b1;
          mem_wdata = new_ent;
          res_nxt   = '{status: STATUS_DONE, slot: 10'(cur_r), entry_low: new_word};
          state_nxt = ST_RESP;
        end else begin
          prev_nxt  = cur_r;
          ent_nxt   = rd_q;
          scan_nxt  = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        mem_raddr = scan_r;
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (rd_free) begin
          mem_we    = 1'b1;
          mem_waddr = scan_r;
          mem_wdata = new_ent;
          state_nxt = ST_IN_LINK;
        end else if (scan_r == LAST_IDX) begin
          res_nxt   = '{status: STATUS_FULL, slot: '0, entry_low: '0};
          state_nxt = ST_RESP;
        end else begin
          scan_nxt  = scan_r + IW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_IN_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = prev_r;
        mem_wdata = {ent_r[EW-1:LW], LW'(scan_r)};
        res_nxt   = '{status: STATUS_DONE, slot: 10'(scan_r), entry_low: new_word};
        state_nxt = ST_RESP;
      end
      ST_DH_CHK: begin
        if (rd_match) begin
          w_nxt = rd_word;
          if (!rd_next || rd_link == LW'(home_r)) begin
            mem_we    = 1'b1;
            mem_waddr = home_r;
            res_nxt   = '{status: STATUS_DONE, slot: 10'(home_r), entry_low: rd_word};
            state_nxt = ST_RESP;
          end else begin
            cur_nxt   = rd_link[IW-1:0];
            state_nxt = ST_DH_RD;
          end
        end else begin
          ent_nxt   = rd_q;
          prev_nxt  = home_r;
          steps_nxt = LW'(1);
          state_nxt = ST_DW_STEP;
        end
      end
      ST_DH_RD: begin
        state_nxt = ST_DH_MOVE;
      end
      ST_DH_MOVE: begin
        // The successor's whole entry, link included, moves into the head.
        mem_we    = 1'b1;
        mem_waddr = home_r;
        mem_wdata = rd_q;
        state_nxt = ST_DH_CLR;
      end
      ST_DH_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        res_nxt   = '{status: STATUS_DONE, slot: 10'(home_r), entry_low: w_r};
        state_nxt = ST_RESP;
      end
      ST_DW_STEP: begin
        if (!ent_next || steps_r == LW'(TABLE_ENTRIES)) begin
          res_nxt   = '{status: STATUS_NO_MATCH, slot: '0, entry_low: '0};
          state_nxt = ST_RESP;
        end else begin
          cur_nxt   = ent_r[IW-1:0];
          state_nxt = ST_ISSUE;
        end
      end
      ST_DW_CHK: begin
        if (rd_match) begin
          w_nxt     = rd_word;
          mem_we    = 1'b1;
          mem_waddr = prev_r;
          mem_wdata = {ent_r[EW-1:LW], rd_link};
          state_nxt = ST_DW_CLR;
        end else begin
          ent_nxt   = rd_q;
          prev_nxt  = cur_r;
          steps_nxt = steps_r + LW'(1);
          state_nxt = ST_DW_STEP;
        end
      end
      ST_DW_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r;
        res_nxt   = '{status: STATUS_DONE, slot: 10'(cur_r), entry_low: w_r};
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output register is loaded when the result is ready and the previous
  // transfer has gone or is being taken in this cycle.
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_RESP && (!out_valid_r || !out_stall)) begin
      out_nxt       = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r   <= req_nxt;
    home_r  <= home_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    scan_r  <= scan_nxt;
    steps_r <= steps_nxt;
    ent_r   <= ent_nxt;
    w_r     <= w_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule

// ----- sv/hpt_mem.sv -----
module hpt_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 107,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hpt_hash.sv -----
module hpt_home_calc #(
  parameter int ENTRIES = 1024,
  parameter int IW      = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   key,
  output logic          done,
  output logic [IW-1:0] home
);

  // Remainder by reciprocal multiplication; key, product, raw remainder and home
  // are registered in turn. The estimated quotient is never too large and falls
  // short by at most one, so a single compare and subtract finishes the remainder.
  localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / ENTRIES);
  localparam logic [16:0] DIV_K   = 17'(ENTRIES);
  localparam logic [32:0] DIVISOR = 33'(ENTRIES);

  logic [31:0]   key_r;
  logic [63:0]   prod_r;
  logic [32:0]   rem_r;
  logic [IW-1:0] home_r;
  logic [3:0]    stage_r;
  logic [48:0]   back;
  logic [32:0]   fixed;

  assign back  = prod_r[63:32] * DIV_K;
  assign fixed = (rem_r >= DIVISOR) ? (rem_r - DIVISOR) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= '0;
    end else begin
      stage_r <= {stage_r[2:0], start};
    end
    if (start) begin
      key_r <= key;
    end
    prod_r <= key_r * RECIP;
    rem_r  <= {1'b0, key_r} - back[32:0];
    home_r <= fixed[IW-1:0];
  end

  assign done = stage_r[3];
  assign home = home_r;

endmodule

// ----- sv/hpt_chk.sv -----
module hpt_chk
  import hpt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != STATUS_RSVD)
    else $error("reserved status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STATUS_DONE |->
      out_data.slot == 10'd0 && out_data.entry_low == 32'd0)
    else $error("failed request carries slot or word");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind hashed_page_table hpt_chk u_hpt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
